/* rtl/hsvrgb_pkg.sv */
`default_nettype none

package hsvrgb_pkg;

    // Field widths
    localparam int HUE_W      = 15;   // signed hue in 1/16 degree
    localparam int CH_W       = 8;    // channel, saturation, value, alpha
    localparam int H_W        = 13;   // wrapped hue, 0..5759
    localparam int G_W        = 10;   // position inside a sector, 0..960
    localparam int PROD_W     = 16;   // 8x8 products
    localparam int NUM_W      = 26;   // rounded channel numerators
    localparam int RECIP_W    = 27;   // reciprocal of the channel denominator
    localparam int PIPE_DEPTH = 5;

    // Hue geometry
    localparam int HUE_FULL   = 5760;
    localparam int HUE_SECTOR = 960;
    localparam int HUE_MIN    = -5760;
    localparam int HUE_MAX    = 11519;
    localparam int NUM_SECT   = 6;

    // Channel scaling: every channel is num / (255 * 960), rounded half up
    localparam int CH_SCALE    = 255;
    localparam int DEN         = CH_SCALE * HUE_SECTOR;
    localparam int HALF_DEN    = DEN / 2;
    localparam int RECIP_SHIFT = 44;
    localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / longint'(DEN);

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

    // Fields that ride alongside the arithmetic
    typedef struct packed {
        t_sector         sector;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] alpha;
        logic            clamp;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [G_W-1:0]    g;
        logic [PROD_W-1:0] vs;   // v * s
        logic [PROD_W-1:0] vn;   // v * (255 - s)
    } t_front;

    // Start of a sector in 1/16 degree
    function automatic logic [H_W-1:0] sector_base(input t_sector sec);
        logic [H_W-1:0] base;
        case (sec)
            SEC_RED_YEL: base = H_W'(0);
            SEC_YEL_GRN: base = H_W'(HUE_SECTOR);
            SEC_GRN_CYN: base = H_W'(2 * HUE_SECTOR);
            SEC_CYN_BLU: base = H_W'(3 * HUE_SECTOR);
            SEC_BLU_MAG: base = H_W'(4 * HUE_SECTOR);
            SEC_MAG_RED: base = H_W'(5 * HUE_SECTOR);
            default:     base = H_W'(0);
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

/* rtl/hsvrgb_front.sv */
`default_nettype none

module hsvrgb_front import hsvrgb_pkg::*; (
    input  wire  logic                    i_clk,
    input  wire  logic [1:0]              i_en,
    input  wire  logic signed [HUE_W-1:0] i_hue,
    input  wire  logic [CH_W-1:0]         i_sat,
    input  wire  logic [CH_W-1:0]         i_val,
    input  wire  logic [CH_W-1:0]         i_alpha,
    output t_front                        o_front
);

    localparam logic signed [HUE_W:0] MIN_X  = (HUE_W+1)'(HUE_MIN);
    localparam logic signed [HUE_W:0] MAX_X  = (HUE_W+1)'(HUE_MAX);
    localparam logic signed [HUE_W:0] FULL_X = (HUE_W+1)'(HUE_FULL);

    // stage 1: clamp and wrap
    logic signed [HUE_W:0] hue_x;
    logic signed [HUE_W:0] wrap_x;
    logic [H_W-1:0]        n_h;
    logic                  n_clamp;
    logic [H_W-1:0]        r_h;
    logic                  r_clamp;
    logic [CH_W-1:0]       r_sat;
    logic [CH_W-1:0]       r_val;
    logic [CH_W-1:0]       r_alpha;

    always_comb begin
        hue_x   = {i_hue[HUE_W-1], i_hue};
        n_clamp = 1'b0;
        if (hue_x < MIN_X) begin
            wrap_x  = '0;
            n_clamp = 1'b1;
        end else if (hue_x < 0) begin
            wrap_x = hue_x + FULL_X;
        end else if (hue_x > MAX_X) begin
            wrap_x  = MAX_X - FULL_X;
            n_clamp = 1'b1;
        end else if (hue_x >= FULL_X) begin
            wrap_x = hue_x - FULL_X;
        end else begin
            wrap_x = hue_x;
        end
        n_h = wrap_x[H_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_h     <= n_h;
            r_clamp <= n_clamp;
            r_sat   <= i_sat;
            r_val   <= i_val;
            r_alpha <= i_alpha;
        end
    end

    // stage 2: sector, position in sector, chroma products
    logic [2:0]     sec_cnt;
    t_sector        sec;
    logic [H_W-1:0] offs;
    logic [G_W-1:0] f;
    t_front         n_front;
    t_front         r_front;

    always_comb begin
        sec_cnt = '0;
        for (int k = 1; k < NUM_SECT; k++) begin
            sec_cnt = sec_cnt + 3'(r_h >= H_W'(k * HUE_SECTOR));
        end
        sec  = t_sector'(sec_cnt);
        offs = r_h - sector_base(sec);
        f    = offs[G_W-1:0];

        n_front.side.sector = sec;
        n_front.side.val    = r_val;
        n_front.side.alpha  = r_alpha;
        n_front.side.clamp  = r_clamp;
        // mirror the position in odd sectors
        n_front.g  = sec_cnt[0] ? (G_W'(HUE_SECTOR) - f) : f;
        n_front.vs = PROD_W'(r_val) * PROD_W'(r_sat);
        n_front.vn = PROD_W'(r_val) * PROD_W'(CH_W'(CH_SCALE) - r_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

`default_nettype wire

/* rtl/hsvrgb_mix.sv */
`default_nettype none

module hsvrgb_mix import hsvrgb_pkg::*; (
    input  wire  logic             i_clk,
    input  wire  logic             i_en,
    input  wire  t_front           i_front,
    output t_side                  o_side,
    output logic [NUM_W-1:0]       o_x_num,
    output logic [NUM_W-1:0]       o_m_num
);

    logic [NUM_W-1:0] n_m_num;
    logic [NUM_W-1:0] n_x_num;
    logic [NUM_W-1:0] r_m_num;
    logic [NUM_W-1:0] r_x_num;
    t_side            r_side;

    // numerators already carry the half-denominator for round to nearest
    always_comb begin
        n_m_num = NUM_W'(i_front.vn) * NUM_W'(HUE_SECTOR) + NUM_W'(HALF_DEN);
        n_x_num = NUM_W'(i_front.vs) * NUM_W'(i_front.g) + n_m_num;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_num <= n_m_num;
            r_x_num <= n_x_num;
            r_side  <= i_front.side;
        end
    end

    assign o_side  = r_side;
    assign o_x_num = r_x_num;
    assign o_m_num = r_m_num;

endmodule

`default_nettype wire

/* rtl/hsvrgb_cdiv.sv */
`default_nettype none

module hsvrgb_cdiv import hsvrgb_pkg::*; (
    input  wire  logic             i_clk,
    input  wire  logic [1:0]       i_en,
    input  wire  logic [NUM_W-1:0] i_num,
    output logic [CH_W-1:0]        o_quo
);

    localparam int PW = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    // stage A: estimate by reciprocal, low by at most one
    logic [PW-1:0]    prod;
    logic [CH_W-1:0]  r_q0;
    logic [NUM_W-1:0] r_num;

    assign prod = PW'(i_num) * PW'(RECIP_K);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q0  <= prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            r_num <= i_num;
        end
    end

    // stage B: correct the estimate from the remainder
    logic [NUM_W-1:0] back;
    logic [NUM_W-1:0] rem;
    logic [CH_W-1:0]  n_quo;
    logic [CH_W-1:0]  r_quo;

    always_comb begin
        back  = NUM_W'(r_q0) * NUM_W'(DEN);
        rem   = r_num - back;
        n_quo = r_q0 + CH_W'(rem >= NUM_W'(DEN));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb_converter_unit.sv */
// Throughput: one beat per clock while the output is ready; each of the five
// stages holds one pixel. Backpressure stalls only the stages that are full;
// bubbles are squeezed out. Reset clears the stage valid bits; data registers
// are not reset.
`default_nettype none

module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // input stream
    input  wire  logic        i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [14:0] hue, [22:15] saturation, [30:23] brightness, [38:31] alpha_in,
    // [39] zero fill
    input  wire  logic [39:0] i_s_axis_tdata,
    // output stream
    output logic              o_m_axis_tvalid,
    input  wire  logic        i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_out
    output logic [31:0]       o_m_axis_tdata,
    // [0] hue_clamped
    output logic              o_m_axis_tuser
);

    // Stage map: 0 clamp/wrap, 1 sector and chroma products,
    // 2 channel numerators, 3 reciprocal estimate, 4 estimate correction.
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH:0]   en;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        en[PIPE_DEPTH] = i_m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    // Unpack the input beat
    logic signed [HUE_W-1:0] in_hue;
    logic [CH_W-1:0]         in_sat;
    logic [CH_W-1:0]         in_val;
    logic [CH_W-1:0]         in_alpha;

    assign in_hue   = i_s_axis_tdata[14:0];
    assign in_sat   = i_s_axis_tdata[22:15];
    assign in_val   = i_s_axis_tdata[30:23];
    assign in_alpha = i_s_axis_tdata[38:31];

    // Stages 0 and 1: hue folding, sector pick, v*s and v*(255-s)
    t_front front;

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_en    (en[1:0]),
        .i_hue   (in_hue),
        .i_sat   (in_sat),
        .i_val   (in_val),
        .i_alpha (in_alpha),
        .o_front (front)
    );

    // Stage 2: numerators of x+m and m
    t_side            mix_side;
    logic [NUM_W-1:0] x_num;
    logic [NUM_W-1:0] m_num;

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (en[2]),
        .i_front (front),
        .o_side  (mix_side),
        .o_x_num (x_num),
        .o_m_num (m_num)
    );

    // Stages 3 and 4: divide both numerators by 255*960
    logic [CH_W-1:0] q_mid;
    logic [CH_W-1:0] q_lo;

    hsvrgb_cdiv u_div_mid (
        .i_clk (i_clk),
        .i_en  (en[4:3]),
        .i_num (x_num),
        .o_quo (q_mid)
    );

    hsvrgb_cdiv u_div_lo (
        .i_clk (i_clk),
        .i_en  (en[4:3]),
        .i_num (m_num),
        .o_quo (q_lo)
    );

    // Carry sector, value, alpha and the clamp flag beside the dividers
    t_side r_side_a;
    t_side r_side_b;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_side_a <= mix_side;
        end
        if (en[4]) begin
            r_side_b <= r_side_a;
        end
    end

    // Route c+m (the value itself), x+m and m by sector
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] hi;

    always_comb begin
        hi = r_side_b.val;
        case (r_side_b.sector)
            SEC_RED_YEL: begin red = hi;    green = q_mid; blue = q_lo;  end
            SEC_YEL_GRN: begin red = q_mid; green = hi;    blue = q_lo;  end
            SEC_GRN_CYN: begin red = q_lo;  green = hi;    blue = q_mid; end
            SEC_CYN_BLU: begin red = q_lo;  green = q_mid; blue = hi;    end
            SEC_BLU_MAG: begin red = q_mid; green = q_lo;  blue = hi;    end
            default:     begin red = hi;    green = q_lo;  blue = q_mid; end
        endcase
    end

    assign o_m_axis_tdata = {r_side_b.alpha, blue, green, red};
    assign o_m_axis_tuser = r_side_b.clamp;

    // A ready sink must never throttle the source.
    a_full_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input stalled while output is ready");

    // One channel always carries the value component.
    a_hi_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (red == hi || green == hi || blue == hi))
        else $error("no channel equals the value component");

    // No channel may exceed the value component.
    a_hi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (red <= hi && green <= hi && blue <= hi))
        else $error("channel above the value component");

endmodule

`default_nettype wire
